[rtl/nta_pkg.sv]
package nta_pkg;

    typedef logic [1:0] op_t;
    localparam op_t OP_LEARN  = 2'd0;
    localparam op_t OP_TICK   = 2'd1;
    localparam op_t OP_LOOKUP = 2'd2;

    typedef logic [1:0] level_t;
    localparam level_t LVL_IP_ONLY  = 2'd0;
    localparam level_t LVL_OWN      = 2'd1;
    localparam level_t LVL_EXTENDED = 2'd2;
    localparam level_t LVL_WITH_PORT = 2'd3;

    typedef logic cfg_index_t;
    localparam cfg_index_t CFG_AGE_LIMIT = 1'b0;
    localparam cfg_index_t CFG_ARP_AGE   = 1'b1;

    localparam logic [3:0]  AGE_LIMIT_RST  = 4'd10;
    localparam logic [3:0]  ARP_AGE_RST    = 4'd8;
    localparam logic [15:0] PORT_MIN_BUILD = 16'd20107;
    localparam logic [15:0] DEFAULT_PORT   = 16'd80;
    localparam logic [7:0]  BROADCAST_UNIT = 8'd255;
    localparam logic [31:0] BROADCAST_IP   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] ip;
        logic [3:0]  age;
        logic [15:0] build;
        logic [7:0]  kind;
        logic [15:0] port;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic sweep;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sweep_last;
    } dp_status_t;

endpackage

[rtl/node_table_with_aging.sv]
// Channel  Handshake          Ports
// -------  -----------------  ------------------------------------------------------
// command  start & !busy      op, unit, ip_addr, info_level, build_number,
//                             node_kind, web_port
// result   done (one cycle)   found_ip, present, found_build, found_kind,
//                             found_port, arp_needed
// config   cfg_we             cfg_index, cfg_wdata
//
// Learn, lookup and the unused op make one entry-RAM read, then the write-back and
// the result register. An aging tick sweeps the single-read-port entry RAM, one
// entry a cycle. busy holds off new transactions while one is in flight. Reset
// clears the valid flip-flops at once, so there is no clearing pass. The result
// cannot be stalled.
module node_table_with_aging
    import nta_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  op_t         op,
    input  logic [7:0]  unit,
    input  logic [31:0] ip_addr,
    input  level_t      info_level,
    input  logic [15:0] build_number,
    input  logic [7:0]  node_kind,
    input  logic [15:0] web_port,
    output logic        done,
    output logic [31:0] found_ip,
    output logic        present,
    output logic [15:0] found_build,
    output logic [7:0]  found_kind,
    output logic [15:0] found_port,
    output logic        arp_needed,
    input  logic        cfg_we,
    input  cfg_index_t  cfg_index,
    input  logic [3:0]  cfg_wdata
);

    ctl_cmd_t   cmd;
    dp_status_t status;

    nta_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (op),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    nta_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .op           (op),
        .unit         (unit),
        .ip_addr      (ip_addr),
        .info_level   (info_level),
        .build_number (build_number),
        .node_kind    (node_kind),
        .web_port     (web_port),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .found_ip     (found_ip),
        .present      (present),
        .found_build  (found_build),
        .found_kind   (found_kind),
        .found_port   (found_port),
        .arp_needed   (arp_needed)
    );

endmodule

[rtl/nta_ram.sv]
module nta_ram
    import nta_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/nta_ctrl.sv]
module nta_ctrl
    import nta_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  op_t        op,
    input  dp_status_t status,
    output ctl_cmd_t   cmd,
    output logic       busy
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EXEC  = 3'b010,
        ST_SWEEP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = (op == OP_TICK) ? ST_SWEEP : ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

[rtl/nta_datapath.sv]
module nta_datapath
    import nta_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256,
    parameter int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctl_cmd_t    cmd,
    output dp_status_t  status,
    input  op_t         op,
    input  logic [7:0]  unit,
    input  logic [31:0] ip_addr,
    input  level_t      info_level,
    input  logic [15:0] build_number,
    input  logic [7:0]  node_kind,
    input  logic [15:0] web_port,
    input  logic        cfg_we,
    input  cfg_index_t  cfg_index,
    input  logic [3:0]  cfg_wdata,
    output logic        done,
    output logic [31:0] found_ip,
    output logic        present,
    output logic [15:0] found_build,
    output logic [7:0]  found_kind,
    output logic [15:0] found_port,
    output logic        arp_needed
);

    // latched transaction
    op_t         op_reg;
    logic [7:0]  unit_reg;
    logic [31:0] ip_reg;
    level_t      level_reg;
    logic [15:0] build_reg;
    logic [7:0]  kind_reg;
    logic [15:0] port_reg;
    logic        in_range_reg;

    logic [3:0]  age_limit_reg;
    logic [3:0]  arp_age_reg;
    logic        valid_reg [TABLE_ENTRIES];
    logic [IDX_W-1:0] cnt_reg;
    logic        arp_reg;

    logic        done_reg;
    logic [31:0] found_ip_reg;
    logic        present_reg;
    logic [15:0] found_build_reg;
    logic [7:0]  found_kind_reg;
    logic [15:0] found_port_reg;
    logic        arp_needed_reg;

    logic [IDX_W-1:0]   uidx;
    logic [IDX_W-1:0]   raddr;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] rdata_raw;
    entry_t             rd_entry;
    entry_t             learn_entry;
    entry_t             wr_entry;
    logic               we;
    logic               old_valid;
    logic               sweep_valid;
    logic               sweep_drop;
    logic               sweep_arp;
    logic               unit_in_range;

    assign uidx          = unit_reg[IDX_W-1:0];
    assign rd_entry      = entry_t'(rdata_raw);
    assign old_valid     = in_range_reg && valid_reg[uidx];
    assign unit_in_range = ({1'b0, unit} < 9'(TABLE_ENTRIES));
    assign status.sweep_last = (cnt_reg == IDX_W'(TABLE_ENTRIES - 1));

    always_comb
    begin
        if (cmd.accept)
        begin
            raddr = (op == OP_TICK) ? '0 : unit[IDX_W-1:0];
        end
        else
        begin
            raddr = cnt_reg + IDX_W'(1);
        end
    end

    // new contents of a learnt entry; a fresh entry starts from zero
    always_comb
    begin
        learn_entry     = old_valid ? rd_entry : '0;
        learn_entry.ip  = ip_reg;
        learn_entry.age = '0;
        if (level_reg != LVL_IP_ONLY)
        begin
            learn_entry.build = build_reg;
            learn_entry.kind  = kind_reg;
        end
        case (level_reg)
            LVL_EXTENDED:  learn_entry.port = DEFAULT_PORT;
            LVL_WITH_PORT: learn_entry.port = (build_reg >= PORT_MIN_BUILD) ?
                                              port_reg : DEFAULT_PORT;
            default:       ;
        endcase
    end

    assign sweep_valid = valid_reg[cnt_reg];
    assign sweep_drop  = (rd_entry.ip[31:24] == 8'd0) || (rd_entry.age >= age_limit_reg);
    assign sweep_arp   = sweep_valid && (rd_entry.ip[31:24] != 8'd0) &&
                         (rd_entry.age > arp_age_reg);

    always_comb
    begin
        we       = 1'b0;
        waddr    = cnt_reg;
        wr_entry = rd_entry;
        if (cmd.exec && op_reg == OP_LEARN && in_range_reg)
        begin
            we       = 1'b1;
            waddr    = uidx;
            wr_entry = learn_entry;
        end
        else if (cmd.sweep && sweep_valid && !sweep_drop)
        begin
            we           = 1'b1;
            wr_entry.age = rd_entry.age + 4'd1;
        end
    end

    nta_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wr_entry),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg       <= op;
            unit_reg     <= unit;
            ip_reg       <= ip_addr;
            level_reg    <= info_level;
            build_reg    <= build_number;
            kind_reg     <= node_kind;
            port_reg     <= web_port;
            in_range_reg <= unit_in_range;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_limit_reg <= AGE_LIMIT_RST;
            arp_age_reg   <= ARP_AGE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_AGE_LIMIT: age_limit_reg <= cfg_wdata;
                CFG_ARP_AGE:   arp_age_reg   <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            cnt_reg <= '0;
            arp_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                cnt_reg <= '0;
                arp_reg <= 1'b0;
            end
            if (cmd.exec && op_reg == OP_LEARN && in_range_reg)
            begin
                valid_reg[uidx] <= 1'b1;
            end
            if (cmd.sweep)
            begin
                cnt_reg <= cnt_reg + IDX_W'(1);
                if (sweep_arp)
                begin
                    arp_reg <= 1'b1;
                end
                if (sweep_valid && sweep_drop)
                begin
                    valid_reg[cnt_reg] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.exec || (cmd.sweep && status.sweep_last);
        end
    end

    always_ff @(posedge clk)
    begin
        found_ip_reg    <= '0;
        present_reg     <= 1'b0;
        found_build_reg <= '0;
        found_kind_reg  <= '0;
        found_port_reg  <= '0;
        arp_needed_reg  <= 1'b0;
        if (cmd.exec)
        begin
            if (op_reg == OP_LEARN && in_range_reg)
            begin
                found_ip_reg    <= (ip_reg[31:24] != 8'd0) ? ip_reg : '0;
                present_reg     <= 1'b1;
                found_build_reg <= learn_entry.build;
                found_kind_reg  <= learn_entry.kind;
                found_port_reg  <= learn_entry.port;
            end
            else if (op_reg == OP_LOOKUP)
            begin
                if (old_valid)
                begin
                    found_ip_reg    <= (rd_entry.ip[31:24] != 8'd0) ? rd_entry.ip : '0;
                    present_reg     <= 1'b1;
                    found_build_reg <= rd_entry.build;
                    found_kind_reg  <= rd_entry.kind;
                    found_port_reg  <= rd_entry.port;
                end
                if (unit_reg == BROADCAST_UNIT)
                begin
                    found_ip_reg <= BROADCAST_IP;
                end
            end
        end
        else if (cmd.sweep)
        begin
            arp_needed_reg <= arp_reg || sweep_arp;
        end
    end

    assign done        = done_reg;
    assign found_ip    = found_ip_reg;
    assign present     = present_reg;
    assign found_build = found_build_reg;
    assign found_kind  = found_kind_reg;
    assign found_port  = found_port_reg;
    assign arp_needed  = arp_needed_reg;

endmodule
